### hw/rtl/gwcs_pkg.sv
package gwcs_pkg;

  // Cell kinds; only a wall counts as a neighbor wall
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_WALL  = 2'd1;
  localparam logic [1:0] CELL_OTHER = 2'd2;

  // Request operations
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int unsigned CFG_DW = 9;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       op;
    logic [1:0] cell_in;
  } gwcs_in_t;

  typedef struct packed {
    logic [1:0] cell_out;
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic       last_cell;
  } gwcs_out_t;

  // Per-cell control: shift one value in, return the line pointer to zero
  typedef struct packed {
    logic shift;
    logic restart;
  } gwcs_shift_t;

  // What one accepted request does along the chain
  typedef struct packed {
    logic       shift1;
    logic       shift2;
    logic       restart;
    logic       p1_int;
    logic       emit;
    logic       em_int;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } gwcs_step_t;

  // 3x3 window; column 0 is the newest, mid[1] is the center
  typedef logic [2:0][1:0] gwcs_row_t;

  typedef struct packed {
    gwcs_row_t top;
    gwcs_row_t mid;
    gwcs_row_t bot;
  } gwcs_win_t;

  // Drop an isolated wall
  function automatic logic [1:0] pass_one(input gwcs_win_t win, input logic interior);
    logic [1:0] v;
    v = win.mid[1];
    if (v != CELL_WALL || !interior) begin
      return v;
    end
    if (win.mid[0] == CELL_WALL || win.mid[2] == CELL_WALL ||
        win.top[1] == CELL_WALL || win.bot[1] == CELL_WALL) begin
      return CELL_WALL;
    end
    return CELL_EMPTY;
  endfunction

  // Fill an empty cell held by two or more orthogonal walls and no diagonal one
  function automatic logic [1:0] pass_two(input gwcs_win_t win, input logic interior);
    logic [1:0] v;
    logic [2:0] orth;
    logic       diag;
    v    = win.mid[1];
    orth = 3'(win.mid[0] == CELL_WALL) + 3'(win.mid[2] == CELL_WALL) +
           3'(win.top[1] == CELL_WALL) + 3'(win.bot[1] == CELL_WALL);
    diag = (win.top[0] == CELL_WALL) || (win.top[2] == CELL_WALL) ||
           (win.bot[0] == CELL_WALL) || (win.bot[2] == CELL_WALL);
    if (v != CELL_EMPTY || !interior) begin
      return v;
    end
    if (!diag && orth > 3'd1) begin
      return CELL_WALL;
    end
    return CELL_EMPTY;
  endfunction

endpackage

### hw/rtl/gwcs_cell.sv
module gwcs_cell import gwcs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gwcs_shift_t                      ctl_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_m1_i,
  input  logic [1:0]                       din_i,
  output gwcs_win_t                        win_o
);

  localparam int unsigned DW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH);

  // Two line delays share one memory: [3:2] two rows back, [1:0] one row back
  logic [3:0]    lb_mem [MAX_WIDTH];
  logic [3:0]    rd_q;
  logic [PW-1:0] ptr_q, ptr_d;
  gwcs_win_t     win_q;

  // Line pointer wraps at the row length
  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.restart) begin
      ptr_d = '0;
    end else if (ctl_i.shift) begin
      if (DW'(ptr_q) == w_m1_i) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PW'(1);
      end
    end
  end

  // Read ahead at the next pointer so the data is ready at the next shift
  always_ff @(posedge clk_i) begin
    rd_q <= lb_mem[ptr_d];
    if (ctl_i.shift) begin
      lb_mem[ptr_q] <= {rd_q[1:0], din_i};
    end
  end

  // Pointer and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      win_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (ctl_i.shift) begin
        win_q.bot <= {win_q.bot[1:0], din_i};
        win_q.mid <= {win_q.mid[1:0], rd_q[1:0]};
        win_q.top <= {win_q.top[1:0], rd_q[3:2]};
      end
    end
  end

  assign win_o = win_q;

endmodule

### hw/rtl/gwcs_ctrl.sv
module gwcs_ctrl import gwcs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [CFG_DW-1:0]                cfg_wdata_i,
  input  logic                             accept_i,
  input  gwcs_in_t                         in_i,
  output gwcs_step_t                       step_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   w_m1_o,
  output logic                             hold_o
);

  localparam int unsigned DW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned CLW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned CMPW = (DW > CFG_DW) ? DW : CFG_DW;
  localparam int unsigned CMPH = (HW > CFG_DW) ? HW : CFG_DW;
  localparam int unsigned W_RST = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int unsigned H_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

  logic [DW-1:0]  w_q, w_d, w_m1_q, w_m2_q;
  logic [DW:0]    w_p1_q;
  logic [HW-1:0]  h_q, h_d, h_m2_q;
  logic [CW-1:0]  total_q;
  logic           hold_q;
  logic [CMPW-1:0] wv;
  logic [CMPH-1:0] hv;
  logic [DW-1:0]  w_clamp;
  logic [HW-1:0]  h_clamp;

  logic [CW-1:0]  rcv_q, p1_q, em_q;
  logic [CW-1:0]  rcv_n, p1_n, em_n;
  logic [CLW-1:0] p1_col_q, em_col_q;
  logic [RW-1:0]  p1_row_q, em_row_q;
  logic           rcv_done, store, act, p1_step, emit, last;
  logic [CW:0]    p1_lim, em_lim;
  logic           p1_int, em_int;

  // Clamp written dimensions to 3..MAX
  always_comb begin
    wv = CMPW'(cfg_wdata_i);
    hv = CMPH'(cfg_wdata_i);
    if (wv < CMPW'(3)) begin
      w_clamp = DW'(3);
    end else if (wv > CMPW'(MAX_WIDTH)) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = DW'(wv);
    end
    if (hv < CMPH'(3)) begin
      h_clamp = HW'(3);
    end else if (hv > CMPH'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(hv);
    end
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  w_d = w_clamp;
        REG_GRID_HEIGHT: h_d = h_clamp;
        default:         w_d = w_q;
      endcase
    end
  end

  // Dimensions and derived limits (derived ones are registered from the stored dimensions)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= DW'(W_RST);
      h_q     <= HW'(H_RST);
      w_m1_q  <= DW'(W_RST - 1);
      w_m2_q  <= DW'(W_RST - 2);
      w_p1_q  <= (DW+1)'(W_RST + 1);
      h_m2_q  <= HW'(H_RST - 2);
      total_q <= CW'(W_RST * H_RST);
      hold_q  <= 1'b0;
    end else begin
      w_q     <= w_d;
      h_q     <= h_d;
      w_m1_q  <= w_q - DW'(1);
      w_m2_q  <= w_q - DW'(2);
      w_p1_q  <= (DW+1)'(w_q) + (DW+1)'(1);
      h_m2_q  <= h_q - HW'(2);
      total_q <= CW'(w_q) * CW'(h_q);
      hold_q  <= cfg_we_i;
    end
  end

  // Decide what this request does: store, pass-one step, emit
  always_comb begin
    rcv_done = (rcv_q == total_q);
    store    = accept_i && !rcv_done && (in_i.op == OP_CELL);
    act      = accept_i && (rcv_done || in_i.op == OP_CELL);
    rcv_n    = rcv_q + CW'(store);
    p1_lim   = (CW+1)'(p1_q) + (CW+1)'(w_p1_q);
    p1_step  = act && (p1_q != total_q) &&
               ((rcv_n == total_q) || (p1_lim < (CW+1)'(rcv_n)));
    p1_n     = p1_q + CW'(p1_step);
    em_lim   = (CW+1)'(em_q) + (CW+1)'(w_p1_q);
    emit     = act && (em_q < p1_n) &&
               ((p1_n == total_q) || (em_lim < (CW+1)'(p1_n)));
    em_n     = em_q + CW'(emit);
    last     = (em_q + CW'(1)) == total_q;
    p1_int   = (p1_row_q != '0) && (HW'(p1_row_q) <= h_m2_q) &&
               (p1_col_q != '0) && (DW'(p1_col_q) <= w_m2_q);
    em_int   = (em_row_q != '0) && (HW'(em_row_q) <= h_m2_q) &&
               (em_col_q != '0) && (DW'(em_col_q) <= w_m2_q);

    step_o.shift1  = store || p1_step;
    step_o.shift2  = p1_step || emit;
    step_o.restart = emit && last;
    step_o.p1_int  = p1_int;
    step_o.emit    = emit;
    step_o.em_int  = em_int;
    step_o.row     = 8'(em_row_q);
    step_o.col     = 8'(em_col_q);
    step_o.last    = last;
  end

  // Frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q    <= '0;
      p1_q     <= '0;
      em_q     <= '0;
      p1_row_q <= '0;
      p1_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
    end else if (cfg_we_i || (emit && last)) begin
      rcv_q    <= '0;
      p1_q     <= '0;
      em_q     <= '0;
      p1_row_q <= '0;
      p1_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
    end else begin
      rcv_q <= rcv_n;
      p1_q  <= p1_n;
      em_q  <= em_n;
      if (p1_step) begin
        if (DW'(p1_col_q) == w_m1_q) begin
          p1_col_q <= '0;
          p1_row_q <= p1_row_q + RW'(1);
        end else begin
          p1_col_q <= p1_col_q + CLW'(1);
        end
      end
      if (emit) begin
        if (DW'(em_col_q) == w_m1_q) begin
          em_col_q <= '0;
          em_row_q <= em_row_q + RW'(1);
        end else begin
          em_col_q <= em_col_q + CLW'(1);
        end
      end
    end
  end

  assign w_m1_o = w_m1_q;
  assign hold_o = hold_q;

endmodule

### hw/rtl/gwcs_ofifo.sv
module gwcs_ofifo import gwcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gwcs_out_t          push_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gwcs_out_t          out_data_o,
  output logic [FIFO_CW-1:0] level_o
);

  gwcs_out_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               pop;

  assign pop = out_valid_o && out_ready_i;

  // Entry storage; space is guaranteed by the input credit check
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop);
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign level_o     = cnt_q;

endmodule

### hw/rtl/grid_wall_cleanup_stencil.sv
// Two-pass wall cleanup on a raster stream of grid cells. Each cell request
// enters a chain of two window cells: the first removes interior walls with
// no orthogonal wall neighbor, the second fills interior empty cells held by
// two or more orthogonal walls and no diagonal wall, judged on the first
// pass's grid. One request is taken per clock cycle while the input is not
// held off; each result passes the step registers and the second window into
// a four-entry output queue that keeps input accepted while results wait and
// there is room. Results trail the input by two rows and two cells, so after
// the last cell 2*W+2 drain requests flush the grid; the result tagged last_cell
// closes the frame and the next cell starts a new one. A configuration write
// restarts the frame and holds the input for one cycle while the grid size
// settles. Line memories hold MAX_WIDTH entries per pass.
module grid_wall_cleanup_stencil import gwcs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gwcs_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gwcs_out_t         out_data_o
);

  localparam int unsigned DW = $clog2(MAX_WIDTH + 1);

  logic               accept, hold;
  logic [DW-1:0]      w_m1;
  gwcs_step_t         step, step_a_q, step_b_q;
  gwcs_win_t          win1, win2;
  logic [1:0]         p1_val;
  gwcs_out_t          res;
  logic [FIFO_CW-1:0] level;
  logic [FIFO_CW:0]   inflight;

  // Credit check: results in the chain plus queued ones must fit the queue
  assign inflight   = (FIFO_CW+1)'(level) + (FIFO_CW+1)'(step_a_q.emit) +
                      (FIFO_CW+1)'(step_b_q.emit);
  assign in_ready_o = !hold && (inflight < (FIFO_CW+1)'(FIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  gwcs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .step_o      (step),
    .w_m1_o      (w_m1),
    .hold_o      (hold)
  );

  // First pass window on the raw grid
  gwcs_cell #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cell_raw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{shift: step.shift1, restart: step.restart || cfg_we_i}),
    .w_m1_i (w_m1),
    .din_i  (in_data_i.cell_in),
    .win_o  (win1)
  );

  // Step flags follow the data one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_a_q <= '0;
      step_b_q <= '0;
    end else begin
      step_a_q <= step;
      step_b_q <= step_a_q;
    end
  end

  assign p1_val = pass_one(win1, step_a_q.p1_int);

  // Second pass window on the first pass's grid
  gwcs_cell #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cell_fp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{shift: step_a_q.shift2, restart: step_a_q.restart || cfg_we_i}),
    .w_m1_i (w_m1),
    .din_i  (p1_val),
    .win_o  (win2)
  );

  // Result assembly
  always_comb begin
    res.cell_out  = pass_two(win2, step_b_q.em_int);
    res.out_row   = step_b_q.row;
    res.out_col   = step_b_q.col;
    res.last_cell = step_b_q.last;
  end

  gwcs_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_b_q.emit),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .level_o     (level)
  );

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gwcs_pkg::*;

  localparam int unsigned MAX_W         = 256;
  localparam int unsigned MAX_H         = 256;
  localparam int unsigned LINE_DEPTH    = 2 * MAX_W + 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 120;
  localparam int unsigned RANDOM_ITEMS  = 290;
  localparam int unsigned MAX_REPORTS   = 10;

  // code 3 is not in the package; the block treats it like CELL_OTHER
  localparam logic [1:0] CELL_OTHER_ALT = 2'd3;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = REG_GRID_WIDTH;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  gwcs_in_t          in_data_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  gwcs_out_t         out_data_o;

  grid_wall_cleanup_stencil u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the cleanup pipeline
  logic [8:0]  width_reg  = 9'd64;
  logic [8:0]  height_reg = 9'd64;
  logic [1:0]  raw_line   [LINE_DEPTH];
  logic [1:0]  first_line [LINE_DEPTH];
  int unsigned cells_in, first_pass_done, cells_out;
  gwcs_out_t   cleaned_q[$];

  // Run statistics
  int unsigned grids_done, size_settings, requests_taken, drains_ignored;
  int unsigned results_checked, mismatches, input_held;

  // Sender burst state and receiver hold requests
  bit          gaps_on = 1'b1;
  int unsigned burst_left;
  int unsigned holds_asked, holds_taken, hold_left;
  int unsigned stall_pct, stall_phase;

  function automatic int unsigned clamp_dim(input logic [8:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned grid_cells();
    return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
  endfunction

  function automatic bit is_interior(input int unsigned idx, input int unsigned w,
                                     input int unsigned h);
    int unsigned r, c;
    r = idx / w;
    c = idx % w;
    return r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w;
  endfunction

  function automatic bit raw_wall(input int unsigned idx);
    return raw_line[idx % LINE_DEPTH] == CELL_WALL;
  endfunction

  function automatic bit first_wall(input int unsigned idx);
    return first_line[idx % LINE_DEPTH] == CELL_WALL;
  endfunction

  // Pass one: an interior wall survives only with an orthogonal wall next to it
  function automatic logic [1:0] lone_wall_removed(input int unsigned m, input int unsigned w,
                                                   input int unsigned h);
    logic [1:0] v;
    v = raw_line[m % LINE_DEPTH];
    if (v != CELL_WALL || !is_interior(m, w, h)) return v;
    if (raw_wall(m - 1) || raw_wall(m + 1) || raw_wall(m - w) || raw_wall(m + w))
      return CELL_WALL;
    return CELL_EMPTY;
  endfunction

  // Pass two: fill an interior empty with two or more walls, all orthogonal
  function automatic logic [1:0] gap_filled(input int unsigned k, input int unsigned w,
                                            input int unsigned h);
    logic [1:0]  v;
    int unsigned orth, diag;
    v = first_line[k % LINE_DEPTH];
    if (v != CELL_EMPTY || !is_interior(k, w, h)) return v;
    orth = first_wall(k - 1) + first_wall(k + 1) + first_wall(k - w) + first_wall(k + w);
    diag = first_wall(k - w - 1) + first_wall(k - w + 1) +
           first_wall(k + w - 1) + first_wall(k + w + 1);
    return (orth + diag > 1 && diag == 0) ? CELL_WALL : CELL_EMPTY;
  endfunction

  function automatic void start_new_grid();
    cells_in        = 0;
    first_pass_done = 0;
    cells_out       = 0;
  endfunction

  // Advance the shadow by one accepted request, queue the cleaned cell it frees
  function automatic void track_request(input gwcs_in_t req);
    int unsigned w, h, total;
    gwcs_out_t   res;
    w     = clamp_dim(width_reg, MAX_W);
    h     = clamp_dim(height_reg, MAX_H);
    total = w * h;
    requests_taken++;
    if (cells_in < total) begin
      if (req.op == OP_DRAIN) begin
        drains_ignored++;
        return;
      end
      raw_line[cells_in % LINE_DEPTH] = req.cell_in;
      cells_in++;
    end
    if (first_pass_done < total &&
        (cells_in == total || first_pass_done + w + 1 < cells_in)) begin
      first_line[first_pass_done % LINE_DEPTH] = lone_wall_removed(first_pass_done, w, h);
      first_pass_done++;
    end
    if (cells_out < first_pass_done &&
        (first_pass_done == total || cells_out + w + 1 < first_pass_done)) begin
      res.cell_out  = gap_filled(cells_out, w, h);
      res.out_row   = 8'(cells_out / w);
      res.out_col   = 8'(cells_out % w);
      res.last_cell = (cells_out + 1 == total);
      cleaned_q.push_back(res);
      cells_out++;
      if (cells_out == total) begin
        start_new_grid();
        grids_done++;
      end
    end
  endfunction

  // Result checker, also counts cycles with the input held off
  always @(posedge clk_i) begin
    gwcs_out_t want;
    bit        bad;
    if (in_valid_i && !in_ready_o) input_held++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (cleaned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: cell %0d row %0d col %0d last %0d",
                   out_data_o.cell_out, out_data_o.out_row, out_data_o.out_col,
                   out_data_o.last_cell);
      end else begin
        want = cleaned_q.pop_front();
        bad  = out_data_o.cell_out !== want.cell_out || out_data_o.out_row !== want.out_row ||
               out_data_o.out_col !== want.out_col || out_data_o.last_cell !== want.last_cell;
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display(
              "mismatch: exp cell %0d at %0d,%0d last %0d, got cell %0d at %0d,%0d last %0d",
              want.cell_out, want.out_row, want.out_col, want.last_cell,
              out_data_o.cell_out, out_data_o.out_row, out_data_o.out_col,
              out_data_o.last_cell);
        end
      end
    end
  end

  // Receiver: random stall phases, plus a long hold when the test asks for one
  always @(posedge clk_i) begin
    if (holds_taken != holds_asked) begin
      holds_taken = holds_asked;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(20, 80);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_phase--;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request and wait for it to be taken; valid stays up afterwards
  task automatic send_req(input gwcs_in_t req);
    int unsigned gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_request(req);
  endtask

  // Drop valid and wait until every predicted cell is out and the pipe is quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cleaned_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes, only called with the block idle; each write restarts the grid
  task automatic configure(input bit set_w, input bit set_h, input logic [8:0] w,
                           input logic [8:0] h);
    if (set_w) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_GRID_WIDTH;
      cfg_wdata_i <= w;
      @(posedge clk_i);
      width_reg = w;
      start_new_grid();
    end
    if (set_h) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_GRID_HEIGHT;
      cfg_wdata_i <= h;
      @(posedge clk_i);
      height_reg = h;
      start_new_grid();
    end
    cfg_we_i <= 1'b0;
    size_settings++;
  endtask

  function automatic logic [1:0] pick_cell(input int unsigned wall_pct);
    if ($urandom_range(99) < wall_pct) return CELL_WALL;
    if ($urandom_range(9) < 7) return CELL_EMPTY;
    return $urandom_range(1) ? CELL_OTHER : CELL_OTHER_ALT;
  endfunction

  // Stream grid cells, with early drains mixed in as noise
  task automatic fill_grid(input int unsigned count, input int unsigned wall_pct,
                           input int unsigned noise_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_req('{op: OP_DRAIN, cell_in: 2'($urandom_range(3))});
      send_req('{op: OP_CELL, cell_in: pick_cell(wall_pct)});
    end
  endtask

  // Push the rest of the grid out; surplus cells act as drain ticks
  task automatic flush_grid(input int unsigned cell_pct);
    int unsigned start;
    start = grids_done;
    while (grids_done == start) begin
      if ($urandom_range(99) < cell_pct)
        send_req('{op: OP_CELL, cell_in: 2'($urandom_range(3))});
      else
        send_req('{op: OP_DRAIN, cell_in: 2'($urandom_range(3))});
    end
  endtask

  // 4x4 grid: a lone wall removed, a gap filled, a fill vetoed by a diagonal wall,
  // other cells kept, drains ignored before the grid is complete
  task automatic test_directed();
    logic [1:0] pattern [16];
    pattern = '{CELL_OTHER, CELL_WALL,  CELL_OTHER_ALT, CELL_EMPTY,
                CELL_EMPTY, CELL_EMPTY, CELL_WALL,      CELL_EMPTY,
                CELL_EMPTY, CELL_WALL,  CELL_EMPTY,     CELL_WALL,
                CELL_EMPTY, CELL_WALL,  CELL_EMPTY,     CELL_EMPTY};
    configure(1'b1, 1'b1, 9'd4, 9'd4);
    send_req('{op: OP_DRAIN, cell_in: CELL_WALL});
    for (int i = 0; i < 16; i++) begin
      if (i == 7) send_req('{op: OP_DRAIN, cell_in: CELL_OTHER_ALT});
      send_req('{op: OP_CELL, cell_in: pattern[i]});
    end
    flush_grid(20);
    wait_idle();
  endtask

  // Clamped sizes: writes below three give a full 3x3 grid; an oversized height
  // is cut to the maximum and streamed for a few rows before it is abandoned
  task automatic test_grid_extremes();
    configure(1'b1, 1'b1, 9'd0, 9'd2);
    fill_grid(grid_cells(), 35, 2);
    flush_grid(5);
    wait_idle();
    configure(1'b1, 1'b1, 9'd4, 9'd511);
    fill_grid(16 * 4, 35, 2);
    wait_idle();
  endtask

  // Receiver holds off long enough for the output path to fill and stall the input
  task automatic test_output_stall();
    configure(1'b1, 1'b1, 9'd8, 9'd6);
    gaps_on = 1'b0;
    holds_asked++;
    fill_grid(grid_cells(), 40, 0);
    flush_grid(0);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Random sizes and contents, back-to-back grids, abandoned grids and pauses
  task automatic test_random_grids();
    int unsigned start, wall_pct, sel, runs;
    logic [8:0]  w, h;
    start = requests_taken - drains_ignored;
    while (requests_taken - drains_ignored - start < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(3) != 0);
      w = ($urandom_range(9) == 0) ? 9'($urandom_range(2)) : 9'($urandom_range(3, 9));
      h = ($urandom_range(9) == 0) ? 9'($urandom_range(2)) : 9'($urandom_range(3, 7));
      sel = $urandom_range(3);
      configure(sel != 2, sel != 1, w, h);
      case ($urandom_range(3))
        0: wall_pct = 15;
        1: wall_pct = 35;
        2: wall_pct = 55;
        default: wall_pct = 75;
      endcase
      if ($urandom_range(7) == 0) begin
        // stop partway; the next register write restarts the grid
        fill_grid($urandom_range(1, grid_cells() - 1), wall_pct, 5);
      end else begin
        runs = $urandom_range(1, 2);
        for (int unsigned g = 0; g < runs; g++) begin
          fill_grid(grid_cells(), wall_pct, 5);
          if ($urandom_range(3) == 0) wait_idle();
          flush_grid(15);
        end
      end
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_grid_extremes();
    test_output_stall();
    test_random_grids();
    $display("Covered %0d grids over %0d size settings: %0d requests taken, %0d early drains.",
             grids_done, size_settings, requests_taken, drains_ignored);
    $display("Checked %0d cleaned cells, %0d cycles of input stall, %0d mismatches.",
             results_checked, input_held, mismatches);
    if (mismatches == 0 && cleaned_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
